// ----- rtl/hslrgb_pkg.sv -----
package hslrgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int HUE_W     = FRAC_BITS;
	localparam int UNIT_W    = FRAC_BITS + 1;
	localparam int DELTA_W   = 18;
	localparam int SUM_W     = UNIT_W + 2;
	localparam int H6_W      = HUE_W + 3;
	localparam int QDEPTH    = 2;

	localparam logic [UNIT_W-1:0] ONE  = UNIT_W'(1) << FRAC_BITS;
	localparam logic [UNIT_W-1:0] HALF = UNIT_W'(1) << (FRAC_BITS - 1);

	localparam logic OP_ADJUST = 1'b0;
	localparam logic OP_SET    = 1'b1;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [UNIT_W-1:0] sat;
		logic [UNIT_W-1:0] light;
	} hsl_t;

	function automatic logic [UNIT_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] v);
		logic [UNIT_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, ONE})) begin
			r = ONE;
		end else begin
			r = v[UNIT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/hslrgb_front.sv -----
module hslrgb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic signed [hslrgb_pkg::DELTA_W-1:0] delta_hue,
	input  logic signed [hslrgb_pkg::DELTA_W-1:0] delta_light,
	input  logic signed [hslrgb_pkg::DELTA_W-1:0] delta_sat,
	input  logic [hslrgb_pkg::HUE_W-1:0]      set_hue,
	input  logic [hslrgb_pkg::UNIT_W-1:0]     set_sat,
	input  logic [hslrgb_pkg::UNIT_W-1:0]     set_light,
	input  logic                              q_full,
	output logic                              push,
	output hslrgb_pkg::hsl_t                  push_data
);

	hslrgb_pkg::hsl_t cur_q;
	hslrgb_pkg::hsl_t nxt;
	logic signed [hslrgb_pkg::SUM_W-1:0] light_sum;
	logic signed [hslrgb_pkg::SUM_W-1:0] sat_sum;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		light_sum = $signed({2'b00, cur_q.light}) + hslrgb_pkg::SUM_W'(delta_light);
		sat_sum   = $signed({2'b00, cur_q.sat}) + hslrgb_pkg::SUM_W'(delta_sat);
		if (opcode == hslrgb_pkg::OP_SET) begin
			nxt.hue   = set_hue;
			nxt.sat   = (set_sat > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : set_sat;
			nxt.light = (set_light > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : set_light;
		end else begin
			nxt.hue   = cur_q.hue + delta_hue[hslrgb_pkg::HUE_W-1:0];
			nxt.sat   = hslrgb_pkg::clamp_sum(sat_sum);
			nxt.light = hslrgb_pkg::clamp_sum(light_sum);
		end
	end

	assign push_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.hue   <= '0;
			cur_q.sat   <= hslrgb_pkg::ONE;
			cur_q.light <= hslrgb_pkg::HALF;
		end else if (push) begin
			cur_q <= nxt;
		end
	end

endmodule

// ----- rtl/hslrgb_queue.sv -----
module hslrgb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hslrgb_pkg::hsl_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output hslrgb_pkg::hsl_t  head
);

	localparam int PTR_W = $clog2(hslrgb_pkg::QDEPTH);
	localparam int CNT_W = $clog2(hslrgb_pkg::QDEPTH + 1);

	hslrgb_pkg::hsl_t  mem_q [hslrgb_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(hslrgb_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/hslrgb_back.sv -----
module hslrgb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  hslrgb_pkg::hsl_t              q_head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hslrgb_pkg::UNIT_W-1:0] red,
	output logic [hslrgb_pkg::UNIT_W-1:0] green,
	output logic [hslrgb_pkg::UNIT_W-1:0] blue
);

	localparam int UW = hslrgb_pkg::UNIT_W;
	localparam int FB = hslrgb_pkg::FRAC_BITS;
	localparam int SW = hslrgb_pkg::SUM_W;

	localparam logic [2:0] SEXT_0 = 3'd0;
	localparam logic [2:0] SEXT_1 = 3'd1;
	localparam logic [2:0] SEXT_2 = 3'd2;
	localparam logic [2:0] SEXT_3 = 3'd3;
	localparam logic [2:0] SEXT_4 = 3'd4;

	logic advance;

	// stage 1: L*S
	logic                         vld_s1;
	logic                         gray_s1;
	logic [UW-1:0]                l_s1;
	logic [UW-1:0]                s_s1;
	logic [hslrgb_pkg::HUE_W-1:0] hue_s1;
	logic [UW-1:0]                lsp_s1;
	logic [2*UW-1:0]              ls_prod;

	// stage 2: m1, m2, sextant, fraction
	logic          vld_s2;
	logic          gray_s2;
	logic [UW-1:0] l_s2;
	logic [UW-1:0] m1_s2;
	logic [UW-1:0] m2_s2;
	logic [2:0]    sext_s2;
	logic [FB-1:0] f_s2;
	logic signed [SW-1:0] m2_raw;
	logic signed [SW-1:0] m1_raw;
	logic [UW-1:0] m2_c;
	logic [UW-1:0] m1_c;
	logic [hslrgb_pkg::H6_W-1:0] h6;

	// stage 3: d = f*(m2-m1)
	logic          vld_s3;
	logic          gray_s3;
	logic [UW-1:0] l_s3;
	logic [UW-1:0] m1_s3;
	logic [UW-1:0] m2_s3;
	logic [2:0]    sext_s3;
	logic [UW-1:0] d_s3;
	logic [FB+UW-1:0] fd_prod;

	logic          out_vld_q;
	logic [UW-1:0] mid1;
	logic [UW-1:0] mid2;
	logic [UW-1:0] r_n;
	logic [UW-1:0] g_n;
	logic [UW-1:0] b_n;

	assign advance   = !out_vld_q || out_ready;
	assign pop       = advance && q_not_empty;
	assign out_valid = out_vld_q;

	assign ls_prod = q_head.light * q_head.sat;

	always_comb begin
		if (l_s1 <= hslrgb_pkg::HALF) begin
			m2_raw = $signed({2'b00, l_s1}) + $signed({2'b00, lsp_s1});
		end else begin
			m2_raw = $signed({2'b00, l_s1}) + $signed({2'b00, s_s1}) - $signed({2'b00, lsp_s1});
		end
		m2_c   = hslrgb_pkg::clamp_sum(m2_raw);
		m1_raw = $signed({1'b0, l_s1, 1'b0}) - $signed({2'b00, m2_c});
		m1_c   = hslrgb_pkg::clamp_sum(m1_raw);
		if (m1_c > m2_c) begin
			m1_c = m2_c;
		end
		h6 = (hslrgb_pkg::H6_W'(hue_s1) << 2) + (hslrgb_pkg::H6_W'(hue_s1) << 1);
	end

	assign fd_prod = f_s2 * (m2_s2 - m1_s2);

	always_comb begin
		mid1 = m1_s3 + d_s3;
		mid2 = m2_s3 - d_s3;
		if (gray_s3) begin
			r_n = l_s3;
			g_n = l_s3;
			b_n = l_s3;
		end else begin
			case (sext_s3)
				SEXT_0: begin
					r_n = m2_s3; g_n = mid1;  b_n = m1_s3;
				end
				SEXT_1: begin
					r_n = mid2;  g_n = m2_s3; b_n = m1_s3;
				end
				SEXT_2: begin
					r_n = m1_s3; g_n = m2_s3; b_n = mid1;
				end
				SEXT_3: begin
					r_n = m1_s3; g_n = mid2;  b_n = m2_s3;
				end
				SEXT_4: begin
					r_n = mid1;  g_n = m1_s3; b_n = m2_s3;
				end
				default: begin
					r_n = m2_s3; g_n = m1_s3; b_n = mid2;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gray_s1 <= (q_head.sat == '0);
			l_s1    <= q_head.light;
			s_s1    <= q_head.sat;
			hue_s1  <= q_head.hue;
			lsp_s1  <= ls_prod[FB +: UW];

			gray_s2 <= gray_s1;
			l_s2    <= l_s1;
			m1_s2   <= m1_c;
			m2_s2   <= m2_c;
			sext_s2 <= h6[FB +: 3];
			f_s2    <= h6[FB-1:0];

			gray_s3 <= gray_s2;
			l_s3    <= l_s2;
			m1_s3   <= m1_s2;
			m2_s3   <= m2_s2;
			sext_s3 <= sext_s2;
			d_s3    <= fd_prod[FB +: UW];

			red   <= r_n;
			green <= g_n;
			blue  <= b_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			vld_s1    <= q_not_empty;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

endmodule

// ----- rtl/hsl_picker_to_rgb_top.sv -----
// HSL picker to RGB converter.
// Input channel (in_valid/in_ready): opcode selects set (absolute hue,
// saturation, lightness) or adjust (signed deltas; hue wraps, sat/light
// clamp to 0..1). Output channel (out_valid/out_ready): red, green, blue in
// Q1.16 for the colour state after that item, one result per item.
// The front stage updates the held HSL state in the accept cycle and pushes
// it into a two-entry queue; the back pipeline converts it to RGB.
// Path from input accept to out_valid: queue write at the accept edge,
// three pipeline stages, output register.
// Throughput: one item per cycle while the receiver does not stall; the
// state update and each multiplier stage are fully pipelined.
// Receiver stall: the back pipeline and output register hold; the queue
// fills and in_ready drops once both entries are occupied.
// Reset: state returns to hue 0, full saturation, half lightness; queue
// and pipeline are emptied.
module hsl_picker_to_rgb_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [hslrgb_pkg::DELTA_W-1:0] delta_hue,
	input  logic signed [hslrgb_pkg::DELTA_W-1:0] delta_light,
	input  logic signed [hslrgb_pkg::DELTA_W-1:0] delta_sat,
	input  logic [hslrgb_pkg::HUE_W-1:0]          set_hue,
	input  logic [hslrgb_pkg::UNIT_W-1:0]         set_sat,
	input  logic [hslrgb_pkg::UNIT_W-1:0]         set_light,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hslrgb_pkg::UNIT_W-1:0]         red,
	output logic [hslrgb_pkg::UNIT_W-1:0]         green,
	output logic [hslrgb_pkg::UNIT_W-1:0]         blue
);

	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	hslrgb_pkg::hsl_t q_wdata;
	hslrgb_pkg::hsl_t q_head;

	hslrgb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.delta_hue   (delta_hue),
		.delta_light (delta_light),
		.delta_sat   (delta_sat),
		.set_hue     (set_hue),
		.set_sat     (set_sat),
		.set_light   (set_light),
		.q_full      (q_full),
		.push        (q_push),
		.push_data   (q_wdata)
	);

	hslrgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	hslrgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule

// ----- rtl/hslrgb_checker.sv -----
module hslrgb_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [hslrgb_pkg::UNIT_W-1:0]         red,
	input logic [hslrgb_pkg::UNIT_W-1:0]         green,
	input logic [hslrgb_pkg::UNIT_W-1:0]         blue
);

	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("result changed while stalled");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red <= hslrgb_pkg::ONE && green <= hslrgb_pkg::ONE
			&& blue <= hslrgb_pkg::ONE)
		else $error("channel above one");

endmodule

bind hsl_picker_to_rgb_top hslrgb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red       (red),
	.green     (green),
	.blue      (blue)
);

// ----- tb/hsl_rgb_checker.sv -----
module hsl_rgb_checker
	import hslrgb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      opcode,
	input  logic signed [DELTA_W-1:0] delta_hue,
	input  logic signed [DELTA_W-1:0] delta_light,
	input  logic signed [DELTA_W-1:0] delta_sat,
	input  logic [HUE_W-1:0]          set_hue,
	input  logic [UNIT_W-1:0]         set_sat,
	input  logic [UNIT_W-1:0]         set_light,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [UNIT_W-1:0]         red,
	input  logic [UNIT_W-1:0]         green,
	input  logic [UNIT_W-1:0]         blue,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT = longint'(1) << FRAC_BITS;

	typedef struct packed {
		logic [UNIT_W-1:0] red;
		logic [UNIT_W-1:0] green;
		logic [UNIT_W-1:0] blue;
	} rgb_t;

	hsl_t colour;
	rgb_t rgb_expected[$];
	int   errors;

	function automatic longint to_unit(input longint v);
		if (v < 0) begin
			return 0;
		end
		if (v > UNIT) begin
			return UNIT;
		end
		return v;
	endfunction

	function automatic hsl_t next_colour(input hsl_t c);
		hsl_t n;
		if (opcode == OP_SET) begin
			n.hue   = set_hue;
			n.sat   = UNIT_W'(to_unit(longint'(set_sat)));
			n.light = UNIT_W'(to_unit(longint'(set_light)));
		end else begin
			// low bits of the signed delta give the wrap modulo one turn
			n.hue   = c.hue + delta_hue[HUE_W-1:0];
			n.light = UNIT_W'(to_unit(longint'(c.light) + longint'(delta_light)));
			n.sat   = UNIT_W'(to_unit(longint'(c.sat) + longint'(delta_sat)));
		end
		return n;
	endfunction

	function automatic rgb_t hsl_to_rgb(input hsl_t c);
		longint l, s, lsp, hi, lo, h6, frac, d, mid1, mid2;
		int     sextant;
		rgb_t   r;
		l = c.light;
		s = c.sat;
		if (s == 0) begin
			r = {UNIT_W'(l), UNIT_W'(l), UNIT_W'(l)};
			return r;
		end
		lsp = (l * s) >> FRAC_BITS;
		hi  = (l <= UNIT / 2) ? l + lsp : l + s - lsp;
		hi  = to_unit(hi);
		lo  = to_unit(2 * l - hi);
		if (lo > hi) begin
			lo = hi;
		end
		h6      = longint'(c.hue) * 6;
		sextant = int'(h6 >> FRAC_BITS);
		frac    = h6 & (UNIT - 1);
		d       = (frac * (hi - lo)) >> FRAC_BITS;
		mid1    = lo + d;
		mid2    = hi - d;
		case (sextant)
			0: r = {UNIT_W'(hi), UNIT_W'(mid1), UNIT_W'(lo)};
			1: r = {UNIT_W'(mid2), UNIT_W'(hi), UNIT_W'(lo)};
			2: r = {UNIT_W'(lo), UNIT_W'(hi), UNIT_W'(mid1)};
			3: r = {UNIT_W'(lo), UNIT_W'(mid2), UNIT_W'(hi)};
			4: r = {UNIT_W'(mid1), UNIT_W'(lo), UNIT_W'(hi)};
			default: r = {UNIT_W'(hi), UNIT_W'(lo), UNIT_W'(mid2)};
		endcase
		return r;
	endfunction

	task automatic check_channel(input string chan, input logic [UNIT_W-1:0] want,
		input logic [UNIT_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, chan, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rgb_t want;
		if (!arst_n) begin
			colour = '{hue: '0, sat: ONE, light: HALF};
			rgb_expected.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				colour = next_colour(colour);
				rgb_expected.push_back(hsl_to_rgb(colour));
			end
			if (out_valid && out_ready) begin
				if (rgb_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, got r=%0d g=%0d b=%0d",
						$time, red, green, blue);
				end else begin
					want = rgb_expected.pop_front();
					check_channel("red", want.red, red);
					check_channel("green", want.green, green);
					check_channel("blue", want.blue, blue);
				end
			end
			fail_count <= errors;
			pending <= rgb_expected.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hslrgb_pkg::*;

	localparam int STIM_ITEMS  = 1450;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic                      opcode;
		logic signed [DELTA_W-1:0] delta_hue;
		logic signed [DELTA_W-1:0] delta_light;
		logic signed [DELTA_W-1:0] delta_sat;
		logic [HUE_W-1:0]          set_hue;
		logic [UNIT_W-1:0]         set_sat;
		logic [UNIT_W-1:0]         set_light;
	} hsl_cmd_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      opcode;
	logic signed [DELTA_W-1:0] delta_hue;
	logic signed [DELTA_W-1:0] delta_light;
	logic signed [DELTA_W-1:0] delta_sat;
	logic [HUE_W-1:0]          set_hue;
	logic [UNIT_W-1:0]         set_sat;
	logic [UNIT_W-1:0]         set_light;
	logic                      out_valid;
	logic                      out_ready;
	logic [UNIT_W-1:0]         red;
	logic [UNIT_W-1:0]         green;
	logic [UNIT_W-1:0]         blue;
	int                        fail_count;
	int                        pending;
	int                        burst_left;
	int                        cycle_cnt;

	hsl_picker_to_rgb_top i_dut (.*);

	hsl_rgb_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic hsl_cmd_t mk(input logic op, input int dh, input int dl, input int ds,
		input int sh, input int ss, input int sl);
		hsl_cmd_t c;
		c.opcode      = op;
		c.delta_hue   = DELTA_W'(dh);
		c.delta_light = DELTA_W'(dl);
		c.delta_sat   = DELTA_W'(ds);
		c.set_hue     = HUE_W'(sh);
		c.set_sat     = UNIT_W'(ss);
		c.set_light   = UNIT_W'(sl);
		return c;
	endfunction

	function automatic logic signed [DELTA_W-1:0] rand_delta();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return DELTA_W'($urandom_range(0, 8192) - 4096);
		end else if (pick < 8) begin
			return DELTA_W'($urandom_range(0, 131072) - 65536);
		end else if (pick == 8) begin
			return DELTA_W'($urandom);
		end
		case ($urandom_range(0, 4))
			0: return DELTA_W'(-131072);
			1: return DELTA_W'(131071);
			2: return DELTA_W'(-65536);
			3: return DELTA_W'(65536);
			default: return '0;
		endcase
	endfunction

	function automatic logic [UNIT_W-1:0] rand_unit();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			return UNIT_W'($urandom_range(0, 65536));
		end else if (pick == 7) begin
			return UNIT_W'($urandom);
		end
		case ($urandom_range(0, 2))
			0: return '0;
			1: return ONE;
			default: return HALF;
		endcase
	endfunction

	function automatic hsl_cmd_t random_cmd();
		hsl_cmd_t c;
		c.opcode      = ($urandom_range(0, 9) < 3) ? OP_SET : OP_ADJUST;
		c.delta_hue   = rand_delta();
		c.delta_light = rand_delta();
		c.delta_sat   = rand_delta();
		c.set_hue     = HUE_W'($urandom);
		c.set_sat     = rand_unit();
		c.set_light   = rand_unit();
		return c;
	endfunction

	task automatic drive(input hsl_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		opcode      <= c.opcode;
		delta_hue   <= c.delta_hue;
		delta_light <= c.delta_light;
		delta_sat   <= c.delta_sat;
		set_hue     <= c.set_hue;
		set_sat     <= c.set_sat;
		set_light   <= c.set_light;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// receiver: segments of random stall density, one long hold-off to fill the block
	initial begin : receiver
		int seg;
		int mode;
		int len;
		seg = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			seg++;
			if (seg == 6) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(10, 80);
				repeat (len) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_ADJUST;
		delta_hue   = '0;
		delta_light = '0;
		delta_sat   = '0;
		set_hue     = '0;
		set_sat     = '0;
		set_light   = '0;
		burst_left  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// colour straight after reset, then grey and the range ends
		drive(mk(OP_ADJUST, 0, 0, 0, 0, 0, 0));
		drive(mk(OP_SET, 0, 0, 0, 0, 0, 32768));
		drive(mk(OP_SET, 0, 0, 0, 65535, 65536, 0));
		drive(mk(OP_SET, 0, 0, 0, 0, 65536, 65536));
		// sextant edges, saturating set values
		drive(mk(OP_SET, 0, 0, 0, 10922, 65536, 32768));
		drive(mk(OP_SET, 0, 0, 0, 10923, 65536, 32769));
		drive(mk(OP_SET, 0, 0, 0, 21846, 131071, 131071));
		drive(mk(OP_SET, 0, 0, 0, 32768, 40000, 20000));
		drive(mk(OP_SET, 0, 0, 0, 45000, 50000, 50000));
		drive(mk(OP_SET, 0, 0, 0, 60000, 65535, 30000));
		// hue reaching exactly one wraps to zero
		drive(mk(OP_SET, 0, 0, 0, 65535, 65536, 32768));
		drive(mk(OP_ADJUST, 1, 0, 0, 0, 0, 0));
		// deltas at and beyond one
		drive(mk(OP_ADJUST, -131072, 131071, -131072, 0, 0, 0));
		drive(mk(OP_ADJUST, 131071, -131072, 131071, 0, 0, 0));
		drive(mk(OP_ADJUST, 65536, -65536, 65536, 0, 0, 0));
		drive(mk(OP_ADJUST, -65536, 65536, -65536, 0, 0, 0));
		drive(mk(OP_ADJUST, -1, -1, -1, 0, 0, 0));
		drive(mk(OP_SET, 0, 0, 0, 21845, 65537, 43690));
		drive(mk(OP_SET, 0, 0, 0, 43690, 43690, 87381));
		drive(mk(OP_ADJUST, 87381, -43691, 43690, 0, 0, 0));
		drive(mk(OP_ADJUST, -87382, 43690, -43691, 0, 0, 0));

		repeat (STIM_ITEMS) drive(random_cmd());
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/hslrgb_pkg.sv
rtl/hslrgb_front.sv
rtl/hslrgb_queue.sv
rtl/hslrgb_back.sv
rtl/hsl_picker_to_rgb_top.sv
rtl/hslrgb_checker.sv
tb/hsl_rgb_checker.sv
tb/tb_top.sv
